// ===== design/stu_pkg.sv =====
// Package for the stabilization tau unit: payload structs, job and arithmetic
// command types, fixed-point constants. Depends on nothing.
`timescale 1ns / 1ps
package stu_pkg;

    // Fraction bits of the velocity, gradient and sum formats
    localparam int FRAC_BITS = 16;

    // term2 is s^2 moved from Q(2F) to Q.32
    localparam bit T2_RIGHT = (2 * FRAC_BITS >= 32);
    localparam int T2_SH    = T2_RIGHT ? (2 * FRAC_BITS - 32) : (32 - 2 * FRAC_BITS);

    // Clip level for every term and the total: 2^96 + 1
    localparam logic [127:0] CAP = (128'd1 << 96) | 128'd1;

    // Queue depths
    localparam int JQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;

    // Configuration register indexes
    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_VISCOSITY = 1'b1;

    localparam logic [31:0] TIME_STEP_RST = 32'd4294967;
    localparam logic [31:0] VISCOSITY_RST = 32'd4295;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic               last_node;
    } item_t;

    typedef struct packed {
        logic [31:0] tau;
        logic        degenerate;
        logic        saturated;
    } result_t;

    // One finished cell handed from front to back
    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] u2;
        logic        clip;
        logic        degen;
    } job_t;

    typedef enum logic [1:0] {
        ARITH_MUL  = 2'd0,
        ARITH_DIV  = 2'd1,
        ARITH_SQRT = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic         start;
        arith_op_t    op;
        logic [127:0] opa;
        logic [127:0] opb;
    } arith_cmd_t;

    typedef struct packed {
        logic         done;
        logic [127:0] quo;
        logic [127:0] rem;
    } arith_rsp_t;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_T1    = 15'h0002,
        S_W_TSQ = 15'h0004,
        S_W_T1  = 15'h0008,
        S_T2    = 15'h0010,
        S_W_A   = 15'h0020,
        S_W_Q1  = 15'h0040,
        S_W_WQA = 15'h0080,
        S_W_VR  = 15'h0100,
        S_W_WQB = 15'h0200,
        S_W_T3  = 15'h0400,
        S_TOT   = 15'h0800,
        S_W_QT  = 15'h1000,
        S_W_SQ  = 15'h2000,
        S_OUT   = 15'h4000
    } back_state_t;

endpackage

// ===== design/stu_front.sv =====
// Front end: per-node dot products, rounding, saturating accumulation and
// the queue of finished cells. Depends on stu_pkg.
`timescale 1ns / 1ps
module stu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  stu_pkg::item_t item,
    output logic           job_valid,
    output stu_pkg::job_t  job,
    input  logic           job_pop
);

    // Stage A: products
    logic                a_valid_reg;
    logic                a_last_reg;
    logic signed [63:0]  p_reg [3];
    logic [63:0]         sq_reg [3];

    // Stage B: rounded magnitude and speed squared
    logic                b_valid_reg;
    logic                b_last_reg;
    logic [63:0]         mag_reg;
    logic [63:0]         u2_reg;
    logic [63:0]         mag_next;
    logic [63:0]         u2_next;

    // Stage C: accumulator
    logic [63:0]         sum_reg, sum_next;
    logic                sclip_reg, sclip_next;

    // Job queue
    stu_pkg::job_t       jq_reg [stu_pkg::JQ_DEPTH];
    logic [1:0]          jq_wr_reg, jq_rd_reg;
    logic [2:0]          jq_cnt_reg;
    logic                jq_push;
    stu_pkg::job_t       jq_in;
    logic                accept;

    // Room must cover every last node still in the pipe
    assign full = (jq_cnt_reg + 3'(a_valid_reg & a_last_reg) + 3'(b_valid_reg & b_last_reg))
                  >= 3'(stu_pkg::JQ_DEPTH);
    assign accept = push && !full;

    // Stage B logic: |u.g| rounded half up to Q FRAC_BITS
    always_comb
    begin
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] diff;
        logic [64:0] rnd;
        pos = '0;
        neg = '0;
        for (int d = 0; d < 3; d++)
        begin
            if (p_reg[d] < 0)
                neg = neg + 64'(-p_reg[d]);
            else
                pos = pos + 64'(p_reg[d]);
        end
        diff = (pos >= neg) ? (pos - neg) : (neg - pos);
        rnd = 65'(diff) + (65'd1 << (stu_pkg::FRAC_BITS - 1));
        mag_next = 64'(rnd >> stu_pkg::FRAC_BITS);
        u2_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    // Stage C logic: saturating add, job on the last node
    always_comb
    begin
        logic [64:0] acc;
        acc = 65'(sum_reg) + 65'(mag_reg);
        sum_next = sum_reg;
        sclip_next = sclip_reg;
        jq_push = 1'b0;
        jq_in = '0;
        if (b_valid_reg)
        begin
            if (acc[64])
            begin
                sum_next = '1;
                sclip_next = 1'b1;
            end
            else
                sum_next = acc[63:0];
            if (b_last_reg)
            begin
                jq_push = 1'b1;
                jq_in.sum = sum_next;
                jq_in.u2 = u2_reg;
                jq_in.clip = sclip_next;
                jq_in.degen = (sum_next == '0);
                sum_next = '0;
                sclip_next = 1'b0;
            end
        end
    end

    assign job_valid = (jq_cnt_reg != '0);
    assign job = jq_reg[jq_rd_reg];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
            sclip_reg   <= 1'b0;
            jq_wr_reg   <= '0;
            jq_rd_reg   <= '0;
            jq_cnt_reg  <= '0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            sum_reg     <= sum_next;
            sclip_reg   <= sclip_next;
            if (jq_push)
                jq_wr_reg <= jq_wr_reg + 2'd1;
            if (job_pop && job_valid)
                jq_rd_reg <= jq_rd_reg + 2'd1;
            jq_cnt_reg <= jq_cnt_reg + 3'(jq_push) - 3'(job_pop && job_valid);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_last_reg <= item.last_node;
        p_reg[0]   <= item.vel_x * item.grad_x;
        p_reg[1]   <= item.vel_y * item.grad_y;
        p_reg[2]   <= item.vel_z * item.grad_z;
        sq_reg[0]  <= 64'(item.vel_x * item.vel_x);
        sq_reg[1]  <= 64'(item.vel_y * item.vel_y);
        sq_reg[2]  <= 64'(item.vel_z * item.vel_z);
        b_last_reg <= a_last_reg;
        mag_reg    <= mag_next;
        u2_reg     <= u2_next;
        if (jq_push)
            jq_reg[jq_wr_reg] <= jq_in;
    end

endmodule

// ===== design/stu_arith.sv =====
// Shared multi-cycle arithmetic: 64x64 multiply in 32-bit partial products,
// 128-bit restoring divide, 64-bit integer square root. Depends on stu_pkg.
`timescale 1ns / 1ps
module stu_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  stu_pkg::arith_cmd_t cmd,
    output stu_pkg::arith_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    stu_pkg::arith_op_t  op_reg, op_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic [127:0]        opa_reg, opa_next;
    logic [127:0]        opb_reg, opb_next;
    logic [127:0]        acc_reg, acc_next;
    logic [128:0]        aux_reg, aux_next;
    logic [63:0]         prod_reg, prod_next;
    logic [6:0]          psh_reg, psh_next;

    always_comb
    begin
        logic [31:0]  ah;
        logic [31:0]  bh;
        logic [128:0] rem_sh;
        logic         qbit;
        logic [64:0]  trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        acc_next  = acc_reg;
        aux_next  = aux_reg;
        prod_next = prod_reg;
        psh_next  = psh_reg;
        ah = '0;
        bh = '0;
        rem_sh = '0;
        qbit = 1'b0;
        trial = '0;
        if (!busy_reg)
        begin
            // Latch a new command
            if (cmd.start)
            begin
                busy_next = 1'b1;
                op_next   = cmd.op;
                cnt_next  = '0;
                opa_next  = cmd.opa;
                opb_next  = cmd.opb;
                acc_next  = '0;
                aux_next  = (cmd.op == stu_pkg::ARITH_SQRT) ? (129'd1 << 62) : '0;
            end
        end
        else
        begin
            case (op_reg)
                stu_pkg::ARITH_MUL:
                begin
                    // one partial product a cycle, added from its register in the next cycle
                    if (cnt_reg != '0)
                        acc_next = acc_reg + (128'(prod_reg) << psh_reg);
                    if (cnt_reg < 7'd4)
                    begin
                        ah = cnt_reg[1] ? opa_reg[63:32] : opa_reg[31:0];
                        bh = cnt_reg[0] ? opb_reg[63:32] : opb_reg[31:0];
                        prod_next = 64'(ah) * 64'(bh);
                        psh_next = (7'(cnt_reg[1]) + 7'(cnt_reg[0])) << 5;
                    end
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd4)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                stu_pkg::ARITH_DIV:
                begin
                    // one quotient bit a cycle
                    rem_sh = {aux_reg[127:0], opa_reg[127]};
                    if (rem_sh >= {1'b0, opb_reg})
                    begin
                        aux_next = rem_sh - {1'b0, opb_reg};
                        qbit = 1'b1;
                    end
                    else
                        aux_next = rem_sh;
                    opa_next = {opa_reg[126:0], 1'b0};
                    acc_next = {acc_reg[126:0], qbit};
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                stu_pkg::ARITH_SQRT:
                begin
                    // one result bit a cycle
                    trial = 65'(acc_reg[63:0]) + 65'(aux_reg[63:0]);
                    if (65'(opa_reg[63:0]) >= trial)
                    begin
                        opa_next = 128'(opa_reg[63:0] - trial[63:0]);
                        acc_next = 128'((acc_reg[63:0] >> 1) + aux_reg[63:0]);
                    end
                    else
                        acc_next = 128'(acc_reg[63:0] >> 1);
                    aux_next = 129'(aux_reg[63:0] >> 2);
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd31)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = acc_reg;
    assign rsp.rem  = aux_reg[127:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= stu_pkg::ARITH_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        acc_reg  <= acc_next;
        aux_reg  <= aux_next;
        prod_reg <= prod_next;
        psh_reg  <= psh_next;
    end

endmodule

// ===== design/stu_back.sv =====
// Back end: sequencer forming term1..term3, the total and tau on the shared
// arithmetic unit, plus the result queue. Depends on stu_pkg.
`timescale 1ns / 1ps
module stu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  stu_pkg::job_t       job,
    output logic                job_pop,
    input  logic [31:0]         time_step,
    input  logic [31:0]         viscosity,
    output stu_pkg::arith_cmd_t cmd,
    input  stu_pkg::arith_rsp_t rsp,
    input  logic                pop,
    output logic                empty,
    output stu_pkg::result_t    result
);

    stu_pkg::back_state_t state_reg, state_next;
    stu_pkg::job_t        job_reg, job_next;
    logic [127:0]         t1_reg, t1_next;
    logic [127:0]         t2_reg, t2_next;
    logic [127:0]         t3_reg, t3_next;
    logic [127:0]         wq_reg, wq_next;
    logic [63:0]          r1_reg, r1_next;
    logic [31:0]          tau_reg, tau_next;
    logic                 clip_reg, clip_next;

    stu_pkg::result_t     rq_reg [stu_pkg::RQ_DEPTH];
    logic                 rq_wr_reg, rq_rd_reg;
    logic [1:0]           rq_cnt_reg;
    logic                 rq_push;
    logic                 rq_pop;

    // Sequencer
    always_comb
    begin
        logic [127:0] tmp;
        logic [127:0] wsum;
        state_next = state_reg;
        job_next   = job_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        t3_next    = t3_reg;
        wq_next    = wq_reg;
        r1_next    = r1_reg;
        tau_next   = tau_reg;
        clip_next  = clip_reg;
        job_pop    = 1'b0;
        rq_push    = 1'b0;
        cmd        = '0;
        tmp        = '0;
        wsum       = '0;
        case (state_reg)
            stu_pkg::S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job;
                    clip_next  = job.clip;
                    t2_next    = '0;
                    t3_next    = '0;
                    state_next = stu_pkg::S_T1;
                end
            end
            stu_pkg::S_T1:
            begin
                if (time_step == '0)
                begin
                    t1_next    = stu_pkg::CAP;
                    clip_next  = 1'b1;
                    state_next = stu_pkg::S_T2;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = stu_pkg::ARITH_MUL;
                    cmd.opa    = 128'(time_step);
                    cmd.opb    = 128'(time_step);
                    state_next = stu_pkg::S_W_TSQ;
                end
            end
            stu_pkg::S_W_TSQ:
            begin
                // term1 = 4 / dt^2 in Q.32
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = stu_pkg::ARITH_DIV;
                    cmd.opa    = 128'd1 << 98;
                    cmd.opb    = rsp.quo;
                    state_next = stu_pkg::S_W_T1;
                end
            end
            stu_pkg::S_W_T1:
            begin
                if (rsp.done)
                begin
                    if (rsp.quo > stu_pkg::CAP)
                    begin
                        t1_next   = stu_pkg::CAP;
                        clip_next = 1'b1;
                    end
                    else
                        t1_next = rsp.quo;
                    state_next = stu_pkg::S_T2;
                end
            end
            stu_pkg::S_T2:
            begin
                if (job_reg.degen)
                    state_next = stu_pkg::S_TOT;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = stu_pkg::ARITH_MUL;
                    cmd.opa    = 128'(job_reg.sum);
                    cmd.opb    = 128'(job_reg.sum);
                    state_next = stu_pkg::S_W_A;
                end
            end
            stu_pkg::S_W_A:
            begin
                // s^2 ready: term2, then start term3 when nu and |u|^2 are nonzero
                if (rsp.done)
                begin
                    if (stu_pkg::T2_RIGHT)
                    begin
                        tmp = rsp.quo >> stu_pkg::T2_SH;
                        if (tmp > stu_pkg::CAP)
                        begin
                            t2_next   = stu_pkg::CAP;
                            clip_next = 1'b1;
                        end
                        else
                            t2_next = tmp;
                    end
                    else
                    begin
                        if (rsp.quo > (stu_pkg::CAP >> stu_pkg::T2_SH))
                        begin
                            t2_next   = stu_pkg::CAP;
                            clip_next = 1'b1;
                        end
                        else
                            t2_next = rsp.quo << stu_pkg::T2_SH;
                    end
                    if (viscosity == '0)
                        state_next = stu_pkg::S_TOT;
                    else if (job_reg.u2 == '0)
                    begin
                        t3_next    = stu_pkg::CAP;
                        clip_next  = 1'b1;
                        state_next = stu_pkg::S_TOT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = stu_pkg::ARITH_DIV;
                        cmd.opa    = rsp.quo;
                        cmd.opb    = 128'(job_reg.u2);
                        state_next = stu_pkg::S_W_Q1;
                    end
                end
            end
            stu_pkg::S_W_Q1:
            begin
                if (rsp.done)
                begin
                    if (rsp.quo[127:64] != '0)
                    begin
                        t3_next    = stu_pkg::CAP;
                        clip_next  = 1'b1;
                        state_next = stu_pkg::S_TOT;
                    end
                    else
                    begin
                        r1_next    = rsp.rem[63:0];
                        cmd.start  = 1'b1;
                        cmd.op     = stu_pkg::ARITH_MUL;
                        cmd.opa    = 128'(viscosity);
                        cmd.opb    = 128'(rsp.quo[63:0]);
                        state_next = stu_pkg::S_W_WQA;
                    end
                end
            end
            stu_pkg::S_W_WQA:
            begin
                if (rsp.done)
                begin
                    wq_next    = rsp.quo;
                    cmd.start  = 1'b1;
                    cmd.op     = stu_pkg::ARITH_MUL;
                    cmd.opa    = 128'(viscosity);
                    cmd.opb    = 128'(r1_reg);
                    state_next = stu_pkg::S_W_VR;
                end
            end
            stu_pkg::S_W_VR:
            begin
                if (rsp.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = stu_pkg::ARITH_DIV;
                    cmd.opa    = rsp.quo;
                    cmd.opb    = 128'(job_reg.u2);
                    state_next = stu_pkg::S_W_WQB;
                end
            end
            stu_pkg::S_W_WQB:
            begin
                // w = nu*s^2/|u|^2 in Q.32
                if (rsp.done)
                begin
                    wsum = wq_reg + 128'(rsp.quo[63:0]);
                    if (wsum[127:64] != '0)
                    begin
                        t3_next    = stu_pkg::CAP;
                        clip_next  = 1'b1;
                        state_next = stu_pkg::S_TOT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = stu_pkg::ARITH_MUL;
                        cmd.opa    = 128'(wsum[63:0]);
                        cmd.opb    = 128'(wsum[63:0]);
                        state_next = stu_pkg::S_W_T3;
                    end
                end
            end
            stu_pkg::S_W_T3:
            begin
                if (rsp.done)
                begin
                    t3_next    = rsp.quo >> 32;
                    state_next = stu_pkg::S_TOT;
                end
            end
            stu_pkg::S_TOT:
            begin
                tmp = t1_reg + t2_reg + t3_reg;
                if (tmp > stu_pkg::CAP)
                begin
                    tmp       = stu_pkg::CAP;
                    clip_next = 1'b1;
                end
                cmd.start  = 1'b1;
                cmd.op     = stu_pkg::ARITH_DIV;
                cmd.opa    = 128'd1 << 96;
                cmd.opb    = tmp;
                state_next = stu_pkg::S_W_QT;
            end
            stu_pkg::S_W_QT:
            begin
                if (rsp.done)
                begin
                    if (rsp.quo[127:64] != '0)
                    begin
                        tau_next   = '1;
                        clip_next  = 1'b1;
                        state_next = stu_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = stu_pkg::ARITH_SQRT;
                        cmd.opa    = 128'(rsp.quo[63:0]);
                        state_next = stu_pkg::S_W_SQ;
                    end
                end
            end
            stu_pkg::S_W_SQ:
            begin
                if (rsp.done)
                begin
                    if (rsp.quo[63:32] != '0)
                    begin
                        tau_next  = '1;
                        clip_next = 1'b1;
                    end
                    else
                        tau_next = rsp.quo[31:0];
                    state_next = stu_pkg::S_OUT;
                end
            end
            stu_pkg::S_OUT:
            begin
                if (rq_cnt_reg != 2'(stu_pkg::RQ_DEPTH))
                begin
                    rq_push    = 1'b1;
                    state_next = stu_pkg::S_IDLE;
                end
            end
            default:
                state_next = stu_pkg::S_IDLE;
        endcase
    end

    // Result queue
    assign empty  = (rq_cnt_reg == '0);
    assign rq_pop = pop && !empty;
    assign result = rq_reg[rq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stu_pkg::S_IDLE;
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rq_push)
                rq_wr_reg <= ~rq_wr_reg;
            if (rq_pop)
                rq_rd_reg <= ~rq_rd_reg;
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_push) - 2'(rq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        t3_reg   <= t3_next;
        wq_reg   <= wq_next;
        r1_reg   <= r1_next;
        tau_reg  <= tau_next;
        clip_reg <= clip_next;
        if (rq_push)
        begin
            rq_reg[rq_wr_reg].tau        <= tau_reg;
            rq_reg[rq_wr_reg].degenerate <= job_reg.degen;
            rq_reg[rq_wr_reg].saturated  <= clip_reg;
        end
    end

endmodule

// ===== design/stabilization_tau_from_gradients_unit.sv =====
// Top level of the SUPG tau unit: configuration registers, front end, back
// end and shared arithmetic. Depends on stu_pkg, stu_front, stu_arith, stu_back.
//
//  channel  | handshake            | beat
//  ---------+----------------------+------------------------------------
//  item     | push / full          | one node: velocity, gradient, last
//  result   | pop / empty          | tau, degenerate, saturated
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Node beats enter at one a cycle, while full is low, through a three-stage front end.
// A last node queues its cell (up to four) for the back end, which works one cell
// at a time through the divides, multiplies and root on the shared arithmetic unit.
// Reset clears the sum, the queues and the sequencer; no clearing pass.
// full rises when the cell queue, counting last nodes still in the front end, has
// no room; results wait in a two-deep queue.
`timescale 1ns / 1ps
module stabilization_tau_from_gradients_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  stu_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output stu_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);

    logic [31:0]         time_step_reg;
    logic [31:0]         viscosity_reg;
    logic                job_valid;
    stu_pkg::job_t       job;
    logic                job_pop;
    stu_pkg::arith_cmd_t cmd;
    stu_pkg::arith_rsp_t rsp;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= stu_pkg::TIME_STEP_RST;
            viscosity_reg <= stu_pkg::VISCOSITY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                stu_pkg::CFG_TIME_STEP: time_step_reg <= cfg_data;
                stu_pkg::CFG_VISCOSITY: viscosity_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    stu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    stu_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    stu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .time_step (time_step_reg),
        .viscosity (viscosity_reg),
        .cmd       (cmd),
        .rsp       (rsp),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // an offered result is fully defined
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(result))
        else $error("unknown result offered");

    // a waiting result stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
        else $error("waiting result changed");

endmodule
